FILE: hw/rtl/dhb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhb_pkg
// Shared types, register indexes and constants of the DCC half-bit classifier.
// ----------------------------------------------------------------------------
package dhb_pkg;

  localparam int unsigned TIMER_W  = 16;
  localparam int unsigned TOTAL_W  = 17;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [TIMER_W-1:0] TIMER_TOP = 16'hFFFF;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_ONE_MIN        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_MAX        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_TOLERANCE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_MIN       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_MAX       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_TOTAL_MAX = 3'd5;

  // reset values, timer ticks at four ticks per microsecond
  localparam logic [TIMER_W-1:0] ONE_MIN_RST        = 16'd208;
  localparam logic [TIMER_W-1:0] ONE_MAX_RST        = 16'd256;
  localparam logic [TIMER_W-1:0] ONE_TOLERANCE_RST  = 16'd44;
  localparam logic [TIMER_W-1:0] ZERO_MIN_RST       = 16'd360;
  localparam logic [TIMER_W-1:0] ZERO_MAX_RST       = 16'd40000;
  localparam logic [TOTAL_W-1:0] ZERO_TOTAL_MAX_RST = 17'd48000;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_ZERO  = 2'd1,
    EV_ONE   = 2'd2,
    EV_RESET = 2'd3
  } ev_t;

  typedef enum logic [1:0] {
    CLS_NONE = 2'd0,
    CLS_ONE  = 2'd1,
    CLS_ZERO = 2'd2
  } cls_t;

  typedef struct packed {
    logic [TIMER_W-1:0] one_min;
    logic [TIMER_W-1:0] one_max;
    logic [TIMER_W-1:0] one_tolerance;
    logic [TIMER_W-1:0] zero_lo;
    logic [TIMER_W-1:0] zero_hi;
    logic [TOTAL_W-1:0] zero_total_max;
  } cfg_t;

  typedef struct packed {
    logic [TIMER_W-1:0] half_period;
    cls_t               cls;
  } half_t;

  typedef struct packed {
    logic not_empty;
    logic full;
  } q_status_t;

endpackage

FILE: hw/rtl/dcc_half_bit_classifier_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcc_half_bit_classifier_core
// Turns timer captures of DCC track-signal edges into zero, one and reset
// events, one result per edge.
// ----------------------------------------------------------------------------
// Each request on the item side is one edge: a 16-bit free-running timer capture plus the
// timer overflow flag. The block takes one request per clock while item_stall is low and
// returns exactly one result per request, in order: the half-period since the previous edge
// and an event code (none, zero bit, one bit, framing reset). A taken request passes the
// combinational front measurement stage into a two-entry queue, and the registered pairing
// stage behind the queue drives the result. The front keeps accepting while the queue has
// room, so a stall on the result side backs up into item_stall only once two requests wait
// in the queue behind the held result, three in all. Configuration registers reset to the
// standard DCC timing at four ticks per microsecond and are to be written by the user only
// while the block is idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module dcc_half_bit_classifier_core
  import dhb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,

  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TOTAL_W-1:0]   cfg_data,

  input  logic                 item_valid,
  output logic                 item_stall,
  input  logic [TIMER_W-1:0]   capture,
  input  logic                 overflow,

  output logic                 result_valid,
  input  logic                 result_stall,
  output logic [1:0]           event_res,
  output logic [TIMER_W-1:0]   half_period
);

  cfg_t      cfg;
  half_t     front_half;
  half_t     q_head;
  q_status_t q_status;
  logic      accept;
  logic      pop;

  // Configuration registers: drop writes to indexes past the list.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.one_min        <= ONE_MIN_RST;
      cfg.one_max        <= ONE_MAX_RST;
      cfg.one_tolerance  <= ONE_TOLERANCE_RST;
      cfg.zero_lo        <= ZERO_MIN_RST;
      cfg.zero_hi        <= ZERO_MAX_RST;
      cfg.zero_total_max <= ZERO_TOTAL_MAX_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ONE_MIN:        cfg.one_min        <= cfg_data[TIMER_W-1:0];
        REG_ONE_MAX:        cfg.one_max        <= cfg_data[TIMER_W-1:0];
        REG_ONE_TOLERANCE:  cfg.one_tolerance  <= cfg_data[TIMER_W-1:0];
        REG_ZERO_MIN:       cfg.zero_lo        <= cfg_data[TIMER_W-1:0];
        REG_ZERO_MAX:       cfg.zero_hi        <= cfg_data[TIMER_W-1:0];
        REG_ZERO_TOTAL_MAX: cfg.zero_total_max <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Hold off new requests only when the queue has no free slot.
  assign item_stall = q_status.full;
  assign accept     = item_valid && !item_stall;

  // Front: measure the half-period and classify it against the windows.
  dhb_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .capture  (capture),
    .overflow (overflow),
    .cfg      (cfg),
    .half     (front_half)
  );

  // Queue: decouple the front from a stalled result side.
  dhb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (front_half),
    .pop       (pop),
    .head      (q_head),
    .status    (q_status)
  );

  // Back: pair halves into bits and register the result.
  dhb_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_status     (q_status),
    .head         (q_head),
    .cfg          (cfg),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .event_res    (event_res),
    .half_period  (half_period)
  );

endmodule

FILE: hw/rtl/dhb_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhb_front
// Measures the half-period of each accepted edge and sorts it into a window.
// ----------------------------------------------------------------------------
module dhb_front
  import dhb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic [TIMER_W-1:0] capture,
  input  logic               overflow,
  input  cfg_t               cfg,
  output half_t              half
);

  logic [TIMER_W-1:0] last_capture;
  logic [TIMER_W-1:0] p;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_capture <= '0;
    end else if (accept) begin
      last_capture <= capture;
    end
  end

  always_comb begin
    // wrapped capture: distance to the top plus the new count, never above top
    if (capture > last_capture) begin
      p = overflow ? TIMER_TOP : (capture - last_capture);
    end else begin
      p = (TIMER_TOP - last_capture) + capture;
    end

    half.half_period = p;
    if ((cfg.one_min < p) && (p < cfg.one_max)) begin
      half.cls = CLS_ONE;
    end else if ((cfg.zero_lo < p) && (p < cfg.zero_hi)) begin
      half.cls = CLS_ZERO;
    end else begin
      half.cls = CLS_NONE;
    end
  end

endmodule

FILE: hw/rtl/dhb_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhb_queue
// Short first-in first-out queue of classified halves between front and back.
// ----------------------------------------------------------------------------
module dhb_queue
  import dhb_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  half_t     push_data,
  input  logic      pop,
  output half_t     head,
  output q_status_t status
);

  localparam logic [QUEUE_AW-1:0] LAST_SLOT = QUEUE_AW'(QUEUE_DEPTH - 1);

  half_t               slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_CW-1:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign head             = slots[rd_ptr];
  assign status.not_empty = (count != '0);
  assign status.full      = (count == QUEUE_CW'(QUEUE_DEPTH));

endmodule

FILE: hw/rtl/dhb_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhb_back
// Pairs classified halves into bits and holds the result for the output side.
// ----------------------------------------------------------------------------
module dhb_back
  import dhb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  q_status_t          q_status,
  input  half_t              head,
  input  cfg_t               cfg,
  output logic               pop,
  output logic               result_valid,
  input  logic               result_stall,
  output logic [1:0]         event_res,
  output logic [TIMER_W-1:0] half_period
);

  logic               pending_one_half;
  logic               pending_zero_half;
  logic [TIMER_W-1:0] first_half_length;
  ev_t                ev_reg;

  logic               pending_one_next;
  logic               pending_zero_next;
  logic [TIMER_W-1:0] first_half_next;
  ev_t                ev_next;
  logic [TIMER_W-1:0] diff;
  logic [TOTAL_W-1:0] zero_sum;

  assign pop = q_status.not_empty && (!result_valid || !result_stall);

  always_comb begin
    diff = (head.half_period >= first_half_length) ?
           (head.half_period - first_half_length) :
           (first_half_length - head.half_period);
    zero_sum = {1'b0, head.half_period} + {1'b0, first_half_length};

    pending_one_next  = pending_one_half;
    pending_zero_next = pending_zero_half;
    first_half_next   = first_half_length;
    ev_next           = EV_NONE;

    case (head.cls)
      CLS_ONE: begin
        if (pending_one_half) begin
          if (diff <= cfg.one_tolerance) begin
            ev_next = EV_ONE;
          end
          pending_one_next = 1'b0;
        end else begin
          pending_one_next  = 1'b1;
          pending_zero_next = 1'b0;
          first_half_next   = head.half_period;
        end
      end
      CLS_ZERO: begin
        if (pending_zero_half) begin
          if (zero_sum <= cfg.zero_total_max) begin
            ev_next = EV_ZERO;
          end
          pending_zero_next = 1'b0;
        end else begin
          pending_zero_next = 1'b1;
          pending_one_next  = 1'b0;
          first_half_next   = head.half_period;
        end
      end
      default: begin
        pending_one_next  = 1'b0;
        pending_zero_next = 1'b0;
        ev_next           = EV_RESET;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_one_half  <= 1'b0;
      pending_zero_half <= 1'b0;
      first_half_length <= '0;
      result_valid      <= 1'b0;
    end else begin
      if (pop) begin
        pending_one_half  <= pending_one_next;
        pending_zero_half <= pending_zero_next;
        first_half_length <= first_half_next;
        result_valid      <= 1'b1;
      end else if (!result_stall) begin
        result_valid      <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      ev_reg      <= ev_next;
      half_period <= head.half_period;
    end
  end

  assign event_res = ev_reg;

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the DCC half-bit classifier: table-driven edges,
// then random edge trains under several timing settings, both sides stalling.
// ----------------------------------------------------------------------------
module tb;
  import dhb_pkg::*;

  // hard stop well past the slowest legal run (~700 requests, long stalls)
  localparam int unsigned RUN_LIMIT_NS = 5_000_000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned MAX_PRINTED = 40;

  // indexes past the register list; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = REG_ZERO_TOTAL_MAX + 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = {CFG_IDX_W{1'b1}};

  typedef struct packed {
    ev_t                ev;
    logic [TIMER_W-1:0] half;
  } edge_result_t;

  // one row of the directed table: absolute capture or step from the last one
  typedef struct packed {
    logic               is_abs;
    logic [TIMER_W-1:0] val;
    logic               ovf;
    logic               typed;
    ev_t                ev;
    logic [TIMER_W-1:0] hp;
  } edge_row_t;

  typedef enum {
    TIMING_DEFAULT, TIMING_ALL_ZERO, TIMING_ALL_MAX, TIMING_OVERLAP,
    TIMING_INVERTED, TIMING_RANDOM_NEAR, TIMING_RANDOM_WIDE
  } timing_kind_t;

  typedef enum {
    GEN_ONE, GEN_ZERO, GEN_BOUNDARY, GEN_RAW, GEN_OVERFLOW
  } gen_kind_t;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [TOTAL_W-1:0]   cfg_data = '0;
  logic                 item_valid = 1'b0;
  logic                 item_stall;
  logic [TIMER_W-1:0]   capture = '0;
  logic                 overflow = 1'b0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  logic [1:0]           event_res;
  logic [TIMER_W-1:0]   half_period;

  dcc_half_bit_classifier_core DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .capture      (capture),
    .overflow     (overflow),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .event_res    (event_res),
    .half_period  (half_period)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("Simulation FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Classifier copy: timing registers and pairing state as the block keeps them
  // --------------------------------------------------------------------------
  logic [TIMER_W-1:0] lim_one_min, lim_one_max, lim_one_tol;
  logic [TIMER_W-1:0] lim_zero_lo, lim_zero_hi;
  logic [TOTAL_W-1:0] lim_zero_total;
  logic [TIMER_W-1:0] prev_capture;
  logic [TIMER_W-1:0] first_half;
  logic               one_half_open;
  logic               zero_half_open;

  // results still owed by the block, oldest first
  edge_result_t expected_edges[$];
  int unsigned  mismatch_count = 0;

  // idling knob for both sides; cleared to get stretches at full rate
  bit idle_on = 1'b1;

  function automatic void load_reset_timing();
    lim_one_min    = ONE_MIN_RST;
    lim_one_max    = ONE_MAX_RST;
    lim_one_tol    = ONE_TOLERANCE_RST;
    lim_zero_lo    = ZERO_MIN_RST;
    lim_zero_hi    = ZERO_MAX_RST;
    lim_zero_total = ZERO_TOTAL_MAX_RST;
    prev_capture   = '0;
    first_half     = '0;
    one_half_open  = 1'b0;
    zero_half_open = 1'b0;
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [TOTAL_W-1:0] d);
    case (idx)
      REG_ONE_MIN:        lim_one_min    = d[TIMER_W-1:0];
      REG_ONE_MAX:        lim_one_max    = d[TIMER_W-1:0];
      REG_ONE_TOLERANCE:  lim_one_tol    = d[TIMER_W-1:0];
      REG_ZERO_MIN:       lim_zero_lo    = d[TIMER_W-1:0];
      REG_ZERO_MAX:       lim_zero_hi    = d[TIMER_W-1:0];
      REG_ZERO_TOTAL_MAX: lim_zero_total = d;
      default: ;
    endcase
  endfunction

  // Measure the half-period of one edge, sort it and advance the pairing state.
  function automatic edge_result_t classify_edge(logic [TIMER_W-1:0] c, logic o);
    edge_result_t       r;
    logic [TIMER_W-1:0] p;
    logic [TIMER_W-1:0] diff;
    // overflow only counts when the capture moved forward; a capture at or
    // below the previous one is taken as a single wrap of the timer
    if (c > prev_capture) begin
      p = o ? TIMER_TOP : c - prev_capture;
    end else begin
      p = TIMER_TOP - prev_capture + c;
    end
    r.ev = EV_NONE;
    r.half = p;
    prev_capture = c;
    // the one window is tested first, so it wins where the windows overlap
    if (lim_one_min < p && p < lim_one_max) begin
      if (one_half_open) begin
        diff = (p >= first_half) ? p - first_half : first_half - p;
        if (diff <= lim_one_tol) r.ev = EV_ONE;
        one_half_open = 1'b0;
      end else begin
        one_half_open  = 1'b1;
        zero_half_open = 1'b0;
        first_half     = p;
      end
    end else if (lim_zero_lo < p && p < lim_zero_hi) begin
      if (zero_half_open) begin
        if ({1'b0, p} + {1'b0, first_half} <= lim_zero_total) r.ev = EV_ZERO;
        zero_half_open = 1'b0;
      end else begin
        zero_half_open = 1'b1;
        one_half_open  = 1'b0;
        first_half     = p;
      end
    end else begin
      // outside both windows: framing lost, drop any open half
      one_half_open  = 1'b0;
      zero_half_open = 1'b0;
      r.ev = EV_RESET;
    end
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatch_count < MAX_PRINTED) $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stall, then compare every accepted result in order
  // --------------------------------------------------------------------------
  int unsigned stall_hold = 0;
  int unsigned stall_roll;

  always @(posedge clk) begin
    if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      stall_roll = $urandom_range(99);
      if (!idle_on || stall_roll < 70) begin
        result_stall <= 1'b0;
        stall_hold <= $urandom_range(6);
      end else if (stall_roll < 95) begin
        result_stall <= 1'b1;
        stall_hold <= $urandom_range(3);
      end else begin
        // a rare long stall to back the block up into item_stall
        result_stall <= 1'b1;
        stall_hold <= $urandom_range(40, 10);
      end
    end
  end

  always @(posedge clk) begin : check_results
    edge_result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_edges.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        want = expected_edges.pop_front();
        if (event_res !== want.ev)
          report_mismatch($sformatf("event_res got %0d want %0d", event_res, want.ev));
        if (half_period !== want.half)
          report_mismatch($sformatf("half_period got %0d want %0d", half_period, want.half));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(99);
    if (!idle_on || roll < 60) return 0;
    if (roll < 92) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  // Drive one edge, hold it until taken, then log what the block owes for it.
  // A typed row carries its own expectation; the classifier copy still runs
  // so that its state follows the block.
  task automatic send_edge(logic [TIMER_W-1:0] c, logic o, logic typed,
                           edge_result_t typed_res);
    int unsigned  gap;
    edge_result_t want;
    gap = pick_gap();
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    capture    <= c;
    overflow   <= o;
    @(posedge clk);
    while (item_stall !== 1'b0) @(posedge clk);
    want = classify_edge(c, o);
    expected_edges.push_back(typed ? typed_res : want);
  endtask

  // Drop valid and hold off until every result is back and the pipe is quiet.
  task automatic wait_idle();
    item_valid <= 1'b0;
    while (expected_edges.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [TOTAL_W-1:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    apply_reg(idx, d);
    @(posedge clk);
  endtask

  // Load one timing setting. The 16-bit registers get a random junk top bit
  // on the port, which the block must drop.
  task automatic program_timing(timing_kind_t kind);
    logic [TIMER_W-1:0] v_one_min, v_one_max, v_one_tol, v_zero_lo, v_zero_hi;
    logic [TOTAL_W-1:0] v_total;
    case (kind)
      TIMING_DEFAULT: begin
        v_one_min = ONE_MIN_RST;   v_one_max = ONE_MAX_RST;  v_one_tol = ONE_TOLERANCE_RST;
        v_zero_lo = ZERO_MIN_RST;  v_zero_hi = ZERO_MAX_RST; v_total = ZERO_TOTAL_MAX_RST;
      end
      TIMING_ALL_ZERO: begin
        // both windows empty: every edge is a framing reset
        v_one_min = '0; v_one_max = '0; v_one_tol = '0;
        v_zero_lo = '0; v_zero_hi = '0; v_total = '0;
      end
      TIMING_ALL_MAX: begin
        // widest windows and limits; the one window takes almost everything
        v_one_min = '0; v_one_max = TIMER_TOP; v_one_tol = TIMER_TOP;
        v_zero_lo = '0; v_zero_hi = TIMER_TOP; v_total = '1;
      end
      TIMING_OVERLAP: begin
        // nested windows, zero tolerance and a tight zero-bit sum
        v_one_min = 16'd100; v_one_max = 16'd700; v_one_tol = '0;
        v_zero_lo = 16'd50; v_zero_hi = 16'd3000; v_total = 17'd400;
      end
      TIMING_INVERTED: begin
        // one window inverted so it never matches; zero pairs still decode
        v_one_min = TIMER_TOP; v_one_max = '0; v_one_tol = TIMER_W'($urandom);
        v_zero_lo = 16'd300; v_zero_hi = 16'd900; v_total = 17'd1200;
      end
      TIMING_RANDOM_NEAR: begin
        v_one_min = TIMER_W'($urandom_range(2000));
        v_one_max = TIMER_W'(int'(v_one_min) + int'($urandom_range(800)));
        v_one_tol = TIMER_W'($urandom_range(200));
        v_zero_lo = TIMER_W'($urandom_range(3000));
        v_zero_hi = TIMER_W'(int'(v_zero_lo) + int'($urandom_range(5000, 1)));
        v_total   = TOTAL_W'($urandom_range(2 * int'(v_zero_hi) + 100));
      end
      default: begin
        v_one_min = TIMER_W'($urandom); v_one_max = TIMER_W'($urandom);
        v_one_tol = TIMER_W'($urandom);
        v_zero_lo = TIMER_W'($urandom); v_zero_hi = TIMER_W'($urandom);
        v_total   = TOTAL_W'($urandom);
      end
    endcase
    write_reg(REG_ONE_MIN,        {1'($urandom_range(1)), v_one_min});
    write_reg(REG_ONE_MAX,        {1'($urandom_range(1)), v_one_max});
    write_reg(REG_ONE_TOLERANCE,  {1'($urandom_range(1)), v_one_tol});
    write_reg(REG_ZERO_MIN,       {1'($urandom_range(1)), v_zero_lo});
    write_reg(REG_ZERO_MAX,       {1'($urandom_range(1)), v_zero_hi});
    write_reg(REG_ZERO_TOTAL_MAX, v_total);
    // a write past the register list must leave every setting alone
    write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_LAST, REG_SPARE_FIRST)),
              TOTAL_W'($urandom));
    cfg_we <= 1'b0;
  endtask

  // Random value a few ticks around [lo, hi], order of the bounds not assumed.
  function automatic int near_range(int lo, int hi);
    int a, b, t;
    a = (lo < 3) ? 0 : lo - 3;
    b = (hi > 65532) ? 65535 : hi + 3;
    if (a > b) begin
      t = a; a = b; b = t;
    end
    return int'($urandom_range(b, a));
  endfunction

  gen_kind_t last_kind = GEN_RAW;
  int        last_target = 0;

  // Mostly well-formed half trains: one halves, zero halves, second halves
  // around the tolerance and the sum limit, window edges; the rest is raw
  // captures and overflow-flagged edges.
  task automatic gen_edge(output logic [TIMER_W-1:0] c, output logic o);
    int        roll, p, t, b;
    gen_kind_t kind;
    o = 1'b0;
    p = 0;
    c = '0;
    roll = $urandom_range(99);
    if (roll < 35) begin
      kind = GEN_ONE;
      if (last_kind == GEN_ONE && $urandom_range(1) == 1) begin
        t = (int'(lim_one_tol) > 1000) ? 1000 : int'(lim_one_tol);
        p = last_target + int'($urandom_range(2 * t + 4)) - (t + 2);
      end else begin
        p = near_range(int'(lim_one_min), int'(lim_one_max));
      end
    end else if (roll < 70) begin
      kind = GEN_ZERO;
      if (last_kind == GEN_ZERO && $urandom_range(2) == 0) begin
        p = int'(lim_zero_total) - last_target + int'($urandom_range(4)) - 2;
      end else if ($urandom_range(1) == 1) begin
        t = int'(lim_zero_lo) + 600;
        p = near_range(int'(lim_zero_lo), (int'(lim_zero_hi) > t) ? t : int'(lim_zero_hi));
      end else begin
        p = near_range(int'(lim_zero_lo), int'(lim_zero_hi));
      end
    end else if (roll < 80) begin
      kind = GEN_BOUNDARY;
      case ($urandom_range(3))
        0:       b = int'(lim_one_min);
        1:       b = int'(lim_one_max);
        2:       b = int'(lim_zero_lo);
        default: b = int'(lim_zero_hi);
      endcase
      p = b + int'($urandom_range(2)) - 1;
    end else if (roll < 90) begin
      kind = GEN_RAW;
      c = TIMER_W'($urandom);
      o = 1'($urandom_range(1));
    end else begin
      kind = GEN_OVERFLOW;
      p = $urandom_range(65535);
      o = 1'b1;
    end
    if (kind != GEN_RAW) begin
      if (p < 0) p = 0;
      if (p > 65535) p = 65535;
      c = prev_capture + p[TIMER_W-1:0];
    end
    last_kind = kind;
    last_target = p;
  endtask

  // --------------------------------------------------------------------------
  // Directed edges under reset timing (one window 208..256, zero 360..40000).
  // Steps are from the previous capture; typed rows are read straight off the
  // rules: equal captures, overflow, wrap to zero, window edges, pair results.
  // --------------------------------------------------------------------------
  edge_row_t dir_tab [0:24] = '{
    '{1'b1, 16'd0,     1'b0, 1'b1, EV_RESET, 16'hFFFF},  // equal captures
    '{1'b1, 16'hFFFF,  1'b1, 1'b1, EV_RESET, 16'hFFFF},  // overflow, capture above
    '{1'b1, 16'd0,     1'b1, 1'b1, EV_RESET, 16'd0},     // overflow ignored on wrap
    '{1'b0, 16'd232,   1'b0, 1'b0, EV_NONE,  16'd0},     // first one half
    '{1'b0, 16'd232,   1'b0, 1'b1, EV_ONE,   16'd232},   // one bit
    '{1'b0, 16'd232,   1'b0, 1'b0, EV_NONE,  16'd0},
    '{1'b0, 16'd300,   1'b0, 1'b1, EV_RESET, 16'd300},   // between windows
    '{1'b0, 16'd400,   1'b0, 1'b0, EV_NONE,  16'd0},     // first zero half
    '{1'b0, 16'd400,   1'b0, 1'b1, EV_ZERO,  16'd400},   // zero bit
    '{1'b0, 16'd30000, 1'b0, 1'b0, EV_NONE,  16'd0},
    '{1'b0, 16'd30000, 1'b0, 1'b0, EV_NONE,  16'd0},     // zero sum too long
    '{1'b1, 16'd100,   1'b0, 1'b0, EV_NONE,  16'd0},     // timer wrap
    '{1'b0, 16'd3839,  1'b0, 1'b0, EV_NONE,  16'd0},
    '{1'b0, 16'd210,   1'b0, 1'b0, EV_NONE,  16'd0},
    '{1'b0, 16'd255,   1'b0, 1'b0, EV_NONE,  16'd0},     // just past tolerance
    '{1'b0, 16'd210,   1'b0, 1'b0, EV_NONE,  16'd0},
    '{1'b0, 16'd254,   1'b0, 1'b0, EV_NONE,  16'd0},     // exactly at tolerance
    '{1'b0, 16'd400,   1'b0, 1'b0, EV_NONE,  16'd0},
    '{1'b0, 16'd232,   1'b0, 1'b0, EV_NONE,  16'd0},     // one half drops zero half
    '{1'b0, 16'd400,   1'b0, 1'b0, EV_NONE,  16'd0},     // zero half drops one half
    '{1'b0, 16'd232,   1'b0, 1'b0, EV_NONE,  16'd0},
    '{1'b0, 16'd208,   1'b0, 1'b1, EV_RESET, 16'd208},   // window edges are open
    '{1'b0, 16'd256,   1'b0, 1'b1, EV_RESET, 16'd256},
    '{1'b0, 16'd360,   1'b0, 1'b1, EV_RESET, 16'd360},
    '{1'b0, 16'd40000, 1'b0, 1'b1, EV_RESET, 16'd40000}
  };

  timing_kind_t plan [0:6] = '{
    TIMING_DEFAULT, TIMING_ALL_ZERO, TIMING_ALL_MAX, TIMING_OVERLAP,
    TIMING_INVERTED, TIMING_RANDOM_NEAR, TIMING_RANDOM_WIDE
  };
  int unsigned plan_len [0:6] = '{120, 40, 80, 130, 90, 100, 100};

  initial begin
    edge_result_t       row_res;
    logic [TIMER_W-1:0] c;
    logic               o;
    load_reset_timing();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // walk the directed table under reset timing
    foreach (dir_tab[i]) begin
      c = dir_tab[i].is_abs ? dir_tab[i].val : prev_capture + dir_tab[i].val;
      row_res.ev   = dir_tab[i].ev;
      row_res.half = dir_tab[i].hp;
      send_edge(c, dir_tab[i].ovf, dir_tab[i].typed, row_res);
    end
    wait_idle();

    // random edge trains, one timing setting per phase, loaded while idle
    foreach (plan[k]) begin
      program_timing(plan[k]);
      for (int unsigned n = 0; n < plan_len[k]; n++) begin
        if (n % 40 == 0) idle_on = ($urandom_range(3) != 0);
        // now and then let the block run dry in the middle of a phase
        if ($urandom_range(99) == 0) wait_idle();
        gen_edge(c, o);
        send_edge(c, o, 1'b0, row_res);
      end
      wait_idle();
    end

    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/dhb_pkg.sv
hw/rtl/dhb_front.sv
hw/rtl/dhb_queue.sv
hw/rtl/dhb_back.sv
hw/rtl/dcc_half_bit_classifier_core.sv
tb/tb.sv
